// File: hw/rtl/mtrs_pkg.sv
// shared constants, payload types and controller/datapath interface for the register server
package mtrs_pkg;

  // sizing
  localparam int MAX_REGS    = 16;
  localparam int REG_WORDS   = 256;
  localparam int HDR_BYTES   = 13;
  localparam int FRAME_DEPTH = HDR_BYTES + 2 * MAX_REGS;
  localparam int FRM_AW      = $clog2(FRAME_DEPTH);
  localparam int CNT_W       = $clog2(FRAME_DEPTH + 1);
  localparam int REG_AW      = $clog2(REG_WORDS);
  localparam int NREG_W      = $clog2(MAX_REGS + 1);
  localparam int HDR_AW      = $clog2(HDR_BYTES);

  // frame layout and lengths
  localparam int MIN_LEN          = 8;
  localparam int READ_LEN         = 12;
  localparam int FC_IDX           = 7;
  localparam int LEN_EXTRA        = 3;
  localparam int READ_HDR_LAST    = 8;
  localparam int WRITE_REPLY_LAST = 11;
  localparam logic [7:0] WRITE_LEN_LO = 8'd6;

  // input modes
  localparam logic [1:0] MODE_NET     = 2'd0;
  localparam logic [1:0] MODE_HOST_WR = 2'd1;
  localparam logic [1:0] MODE_HOST_RD = 2'd2;

  // function codes
  localparam logic [7:0] FC_READ  = 8'd3;
  localparam logic [7:0] FC_WRITE = 8'd16;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FUNC  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_FRAME = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  rx_byte;
    logic        rx_last;
    logic [7:0]  host_addr;
    logic [15:0] host_data;
  } req_t;

  typedef struct packed {
    logic [7:0]  tx_byte;
    logic        tx_last;
    logic [15:0] host_rdata;
    logic [1:0]  status;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic take;
    logic clr_inc;
    logic check;
    logic emit_err;
    logic emit_hdr;
    logic rd_issue;
    logic emit_hi;
    logic emit_lo;
    logic fetch0;
    logic fetch1;
    logic store_word;
    logic host_emit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       clr_last;
    logic       host_in_range;
    logic [1:0] chk_code;
    logic       chk_wr;
    logic       is_wr;
    logic       hdr_last;
    logic       reg_last;
  } dp_sts_t;

endpackage

// File: hw/rtl/mtrs_ram.sv
// generic single write port ram with registered read
module mtrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/mtrs_ctrl.sv
// controller state machine: sequences clearing, frame checks, replies and host accesses
module mtrs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [1:0]         mode,
  input  logic               rx_last,
  input  mtrs_pkg::dp_sts_t  sts,
  output mtrs_pkg::dp_cmd_t  cmd,
  output logic               busy
);

  typedef enum logic [10:0] {
    S_CLEAR   = 11'b000_0000_0001,
    S_IDLE    = 11'b000_0000_0010,
    S_CHECK   = 11'b000_0000_0100,
    S_HDR     = 11'b000_0000_1000,
    S_RD_ADDR = 11'b000_0001_0000,
    S_RD_HI   = 11'b000_0010_0000,
    S_RD_LO   = 11'b000_0100_0000,
    S_WR_B0   = 11'b000_1000_0000,
    S_WR_B1   = 11'b001_0000_0000,
    S_WR_ST   = 11'b010_0000_0000,
    S_HOST_RD = 11'b100_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.clr_inc = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd.take = start;
        if (start) begin
          case (mode)
            mtrs_pkg::MODE_NET: begin
              if (rx_last) begin
                state_next = S_CHECK;
              end
            end
            mtrs_pkg::MODE_HOST_RD: begin
              if (sts.host_in_range) begin
                state_next = S_HOST_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (sts.chk_code != mtrs_pkg::ST_OK) begin
          cmd.emit_err = 1'b1;
          state_next   = S_IDLE;
        end else if (sts.chk_wr) begin
          state_next = S_WR_B0;
        end else begin
          state_next = S_HDR;
        end
      end
      S_HDR: begin
        cmd.emit_hdr = 1'b1;
        if (sts.hdr_last) begin
          state_next = sts.is_wr ? S_IDLE : S_RD_ADDR;
        end
      end
      S_RD_ADDR: begin
        cmd.rd_issue = 1'b1;
        state_next   = S_RD_HI;
      end
      S_RD_HI: begin
        cmd.emit_hi = 1'b1;
        state_next  = S_RD_LO;
      end
      S_RD_LO: begin
        cmd.emit_lo = 1'b1;
        state_next  = sts.reg_last ? S_IDLE : S_RD_ADDR;
      end
      S_WR_B0: begin
        cmd.fetch0 = 1'b1;
        state_next = S_WR_B1;
      end
      S_WR_B1: begin
        cmd.fetch1 = 1'b1;
        state_next = S_WR_ST;
      end
      S_WR_ST: begin
        cmd.store_word = 1'b1;
        state_next     = sts.reg_last ? S_HDR : S_WR_B0;
      end
      S_HOST_RD: begin
        cmd.host_emit = 1'b1;
        state_next    = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

`ifndef SYNTH
  // at most one result source per cycle
  a_one_emit: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.emit_err, cmd.emit_hdr, cmd.emit_hi, cmd.emit_lo, cmd.host_emit}))
    else $error("two result sources in one cycle");

  // a frame end is always checked next
  a_frame_check: assert property (@(posedge clk) disable iff (rst)
    cmd.take && mode == mtrs_pkg::MODE_NET && rx_last |=> state == S_CHECK)
    else $error("frame end not followed by check");

  // a register read is always followed by its first byte
  a_rd_hi: assert property (@(posedge clk) disable iff (rst)
    state == S_RD_ADDR |=> state == S_RD_HI)
    else $error("read issue not followed by first byte");

  // the last stored word of a write starts the echo
  a_wr_echo: assert property (@(posedge clk) disable iff (rst)
    state == S_WR_ST && sts.reg_last |=> state == S_HDR && $past(cmd.store_word))
    else $error("write not followed by echo");
`endif

endmodule

// File: hw/rtl/mtrs_dp.sv
// datapath: frame capture, frame checks, register store and result register
module mtrs_dp (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  input  mtrs_pkg::req_t     req,
  input  mtrs_pkg::dp_cmd_t  cmd,
  output mtrs_pkg::dp_sts_t  sts,
  output mtrs_pkg::rsp_t     rsp,
  output logic               rsp_valid
);

  localparam logic [mtrs_pkg::HDR_AW-1:0] POS_LEN_HI = mtrs_pkg::HDR_AW'(4);
  localparam logic [mtrs_pkg::HDR_AW-1:0] POS_LEN_LO = mtrs_pkg::HDR_AW'(5);
  localparam logic [mtrs_pkg::HDR_AW-1:0] POS_BCNT   = mtrs_pkg::HDR_AW'(8);

  logic                             swap;
  logic [mtrs_pkg::CNT_W-1:0]       frm_cnt;
  logic                             frm_ovf;
  logic [7:0]                       hdr [mtrs_pkg::HDR_BYTES];
  logic [mtrs_pkg::REG_AW-1:0]      base;
  logic [mtrs_pkg::NREG_W-1:0]      nregs;
  logic [mtrs_pkg::NREG_W-1:0]      ptr;
  logic                             is_wr;
  logic [mtrs_pkg::HDR_AW-1:0]      step;
  logic [mtrs_pkg::REG_AW-1:0]      clr_addr;
  logic [7:0]                       b0;

  logic                             net_take;
  logic                             host_wr;
  logic                             host_rd;
  logic                             host_rd_bad;
  logic                             host_in_range;
  logic [mtrs_pkg::REG_AW-1:0]      host_idx;
  logic [mtrs_pkg::REG_AW-1:0]      reg_idx;

  logic [7:0]                       fc;
  logic [15:0]                      addr_w;
  logic [15:0]                      n_w;
  logic                             range_ok;
  logic [16:0]                      exp_len;
  logic [1:0]                       chk_code;

  logic                             frm_we;
  logic                             frm_re;
  logic [mtrs_pkg::FRM_AW-1:0]      frm_raddr;
  logic [7:0]                       frm_rdata;
  logic [mtrs_pkg::FRM_AW-1:0]      frm_rd_base;

  logic                             reg_we;
  logic [mtrs_pkg::REG_AW-1:0]      reg_waddr;
  logic [15:0]                      reg_wdata;
  logic                             reg_re;
  logic [mtrs_pkg::REG_AW-1:0]      reg_raddr;
  logic [15:0]                      reg_rdata;

  logic [15:0]                      len_field;
  logic [7:0]                       hdr_byte;
  logic                             emit_any;
  mtrs_pkg::rsp_t                   rsp_next;

  // input decode
  assign net_take      = cmd.take && (req.mode == mtrs_pkg::MODE_NET);
  assign host_in_range = (32'(req.host_addr) < mtrs_pkg::REG_WORDS);
  assign host_idx      = mtrs_pkg::REG_AW'(req.host_addr);
  assign host_wr       = cmd.take && (req.mode == mtrs_pkg::MODE_HOST_WR) && host_in_range;
  assign host_rd       = cmd.take && (req.mode == mtrs_pkg::MODE_HOST_RD) && host_in_range;
  assign host_rd_bad   = cmd.take && (req.mode == mtrs_pkg::MODE_HOST_RD) && !host_in_range;
  assign reg_idx       = base + mtrs_pkg::REG_AW'(ptr);

  // byte order option
  always_ff @(posedge clk) begin
    if (rst) begin
      swap <= 1'b0;
    end else if (cfg_we) begin
      swap <= cfg_wdata;
    end
  end

  // frame capture counters
  assign frm_we = net_take && (32'(frm_cnt) < mtrs_pkg::FRAME_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      frm_cnt <= '0;
      frm_ovf <= 1'b0;
    end else if (cmd.check) begin
      frm_cnt <= '0;
      frm_ovf <= 1'b0;
    end else if (net_take) begin
      if (frm_we) begin
        frm_cnt <= frm_cnt + mtrs_pkg::CNT_W'(1);
      end else begin
        frm_ovf <= 1'b1;
      end
    end
  end

  // header bytes kept in flops for direct access
  always_ff @(posedge clk) begin
    if (frm_we && (32'(frm_cnt) < mtrs_pkg::HDR_BYTES)) begin
      hdr[frm_cnt[mtrs_pkg::HDR_AW-1:0]] <= req.rx_byte;
    end
  end

  // frame checks on the complete frame
  assign fc       = hdr[mtrs_pkg::FC_IDX];
  assign addr_w   = {hdr[8], hdr[9]};
  assign n_w      = {hdr[10], hdr[11]};
  assign range_ok = (n_w != 16'd0) && (32'(n_w) <= mtrs_pkg::MAX_REGS) &&
                    (({1'b0, addr_w} + {1'b0, n_w}) <= 17'(mtrs_pkg::REG_WORDS));
  assign exp_len  = 17'(mtrs_pkg::HDR_BYTES) + {n_w, 1'b0};

  always_comb begin
    if (frm_ovf || (32'(frm_cnt) < mtrs_pkg::MIN_LEN)) begin
      chk_code = mtrs_pkg::ST_FRAME;
    end else if (fc != mtrs_pkg::FC_READ && fc != mtrs_pkg::FC_WRITE) begin
      chk_code = mtrs_pkg::ST_FUNC;
    end else if (fc == mtrs_pkg::FC_READ) begin
      if (32'(frm_cnt) != mtrs_pkg::READ_LEN) begin
        chk_code = mtrs_pkg::ST_FRAME;
      end else if (!range_ok) begin
        chk_code = mtrs_pkg::ST_RANGE;
      end else begin
        chk_code = mtrs_pkg::ST_OK;
      end
    end else if (32'(frm_cnt) < mtrs_pkg::HDR_BYTES) begin
      chk_code = mtrs_pkg::ST_FRAME;
    end else if (!range_ok || ({9'd0, hdr[12]} != {n_w, 1'b0})) begin
      chk_code = mtrs_pkg::ST_RANGE;
    end else if (17'(frm_cnt) != exp_len) begin
      chk_code = mtrs_pkg::ST_FRAME;
    end else begin
      chk_code = mtrs_pkg::ST_OK;
    end
  end

  // request fields latched at check
  always_ff @(posedge clk) begin
    if (cmd.check) begin
      base  <= addr_w[mtrs_pkg::REG_AW-1:0];
      nregs <= n_w[mtrs_pkg::NREG_W-1:0];
    end
  end

  // reply counters
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr   <= '0;
      step  <= '0;
      is_wr <= 1'b0;
    end else if (cmd.check) begin
      ptr   <= '0;
      step  <= '0;
      is_wr <= (fc == mtrs_pkg::FC_WRITE);
    end else begin
      if (cmd.store_word || cmd.emit_lo) begin
        ptr <= ptr + mtrs_pkg::NREG_W'(1);
      end
      if (cmd.emit_hdr) begin
        step <= step + mtrs_pkg::HDR_AW'(1);
      end
    end
  end

  // clearing sweep over the register store after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_inc) begin
      clr_addr <= clr_addr + mtrs_pkg::REG_AW'(1);
    end
  end

  // frame store
  assign frm_rd_base = mtrs_pkg::FRM_AW'(mtrs_pkg::HDR_BYTES) +
                       mtrs_pkg::FRM_AW'({ptr, 1'b0});
  assign frm_re      = cmd.fetch0 || cmd.fetch1;
  assign frm_raddr   = cmd.fetch1 ? frm_rd_base + mtrs_pkg::FRM_AW'(1) : frm_rd_base;

  mtrs_ram #(
    .WIDTH (8),
    .DEPTH (mtrs_pkg::FRAME_DEPTH)
  ) u_frm_ram (
    .clk   (clk),
    .we    (frm_we),
    .waddr (frm_cnt[mtrs_pkg::FRM_AW-1:0]),
    .wdata (req.rx_byte),
    .re    (frm_re),
    .raddr (frm_raddr),
    .rdata (frm_rdata)
  );

  // first byte of a written word
  always_ff @(posedge clk) begin
    if (cmd.fetch1) begin
      b0 <= frm_rdata;
    end
  end

  // register store port muxing
  always_comb begin
    reg_we    = 1'b0;
    reg_waddr = clr_addr;
    reg_wdata = '0;
    if (cmd.clr_inc) begin
      reg_we = 1'b1;
    end else if (host_wr) begin
      reg_we    = 1'b1;
      reg_waddr = host_idx;
      reg_wdata = req.host_data;
    end else if (cmd.store_word) begin
      reg_we    = 1'b1;
      reg_waddr = reg_idx;
      reg_wdata = swap ? {frm_rdata, b0} : {b0, frm_rdata};
    end
  end

  assign reg_re    = host_rd || cmd.rd_issue;
  assign reg_raddr = host_rd ? host_idx : reg_idx;

  mtrs_ram #(
    .WIDTH (16),
    .DEPTH (mtrs_pkg::REG_WORDS)
  ) u_reg_ram (
    .clk   (clk),
    .we    (reg_we),
    .waddr (reg_waddr),
    .wdata (reg_wdata),
    .re    (reg_re),
    .raddr (reg_raddr),
    .rdata (reg_rdata)
  );

  // reply header byte for the current step
  assign len_field = 16'({nregs, 1'b0}) + 16'(mtrs_pkg::LEN_EXTRA);

  always_comb begin
    hdr_byte = hdr[step];
    if (!is_wr) begin
      case (step)
        POS_LEN_HI: hdr_byte = len_field[15:8];
        POS_LEN_LO: hdr_byte = len_field[7:0];
        POS_BCNT:   hdr_byte = 8'({nregs, 1'b0});
        default:    hdr_byte = hdr[step];
      endcase
    end else begin
      case (step)
        POS_LEN_HI: hdr_byte = 8'd0;
        POS_LEN_LO: hdr_byte = mtrs_pkg::WRITE_LEN_LO;
        default:    hdr_byte = hdr[step];
      endcase
    end
  end

  // result item selection
  assign emit_any = cmd.emit_err || cmd.emit_hdr || cmd.emit_hi || cmd.emit_lo ||
                    cmd.host_emit || host_rd_bad;

  always_comb begin
    rsp_next = '0;
    if (cmd.emit_err) begin
      rsp_next.tx_last = 1'b1;
      rsp_next.status  = chk_code;
    end else if (host_rd_bad) begin
      rsp_next.tx_last = 1'b1;
      rsp_next.status  = mtrs_pkg::ST_RANGE;
    end else if (cmd.host_emit) begin
      rsp_next.tx_last    = 1'b1;
      rsp_next.host_rdata = reg_rdata;
    end else if (cmd.emit_hdr) begin
      rsp_next.tx_byte = hdr_byte;
      rsp_next.tx_last = is_wr && (32'(step) == mtrs_pkg::WRITE_REPLY_LAST);
    end else if (cmd.emit_hi) begin
      rsp_next.tx_byte = swap ? reg_rdata[7:0] : reg_rdata[15:8];
    end else if (cmd.emit_lo) begin
      rsp_next.tx_byte = swap ? reg_rdata[15:8] : reg_rdata[7:0];
      rsp_next.tx_last = sts.reg_last;
    end
  end

  // result register and strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else begin
      rsp_valid <= emit_any;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_any) begin
      rsp <= rsp_next;
    end
  end

  // status to the controller
  assign sts.clr_last      = (clr_addr == mtrs_pkg::REG_AW'(mtrs_pkg::REG_WORDS - 1));
  assign sts.host_in_range = host_in_range;
  assign sts.chk_code      = chk_code;
  assign sts.chk_wr        = (fc == mtrs_pkg::FC_WRITE);
  assign sts.is_wr         = is_wr;
  assign sts.hdr_last      = is_wr ? (32'(step) == mtrs_pkg::WRITE_REPLY_LAST)
                                   : (32'(step) == mtrs_pkg::READ_HDR_LAST);
  assign sts.reg_last      = (ptr == nregs - mtrs_pkg::NREG_W'(1));

endmodule

// File: hw/rtl/modbus_tcp_register_server.sv
// top level of the modbus tcp holding register server
//
// channel   direction  handshake                    payload
// request   in         start high while busy low    req (mtrs_pkg::req_t)
// result    out        rsp_valid strobe, one cycle  rsp (mtrs_pkg::rsp_t)
// config    in         cfg_we                       cfg_wdata (byte swap option)
//
// a request byte without the last mark, a host write and an out-of-range host read are
// taken in idle; an in-range host read passes a host read state. a frame end goes to a
// check state, then for a read to the reply header and three states per register (issue,
// high byte, low byte), or for a write to three states per register (two frame store
// fetches, the store) and the echo header. after reset the register store is cleared
// over all REG_WORDS (256) words with busy high; the receiver cannot stall.
module modbus_tcp_register_server (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  mtrs_pkg::req_t  req,
  output mtrs_pkg::rsp_t  rsp,
  output logic            rsp_valid,
  input  logic            cfg_we,
  input  logic            cfg_wdata
);

  mtrs_pkg::dp_cmd_t cmd;
  mtrs_pkg::dp_sts_t sts;

  // sequencing
  mtrs_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .mode    (req.mode),
    .rx_last (req.rx_last),
    .sts     (sts),
    .cmd     (cmd),
    .busy    (busy)
  );

  // storage and result formation
  mtrs_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp       (rsp),
    .rsp_valid (rsp_valid)
  );

endmodule
